>>> design/cfi_edge_hash_table_defines.svh
// Assertion macros used by the checker file.
`ifndef CFI_EDGE_HASH_TABLE_DEFINES_SVH
`define CFI_EDGE_HASH_TABLE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define CEHT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle.
`define CEHT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> design/ceht_pkg.sv
// Package: types, constants and the bucket hash of the edge hash table.
package ceht_pkg;
  localparam int NumBucketsDef = 256;
  localparam int SlotsPerBucketDef = 8;
  localparam int TargetsPerSourceDef = 8;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_PRESENT     = 3'd3,
    ST_BUCKET_FULL = 3'd4,
    ST_LIST_FULL   = 3'd5
  } status_t;

  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] source_addr;
    logic [31:0] target_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] target_index;
  } out_item_t;

  // Advance the reflected CRC-32 by one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction
endpackage

>>> design/ceht_ram.sv
// Generic RAM with one write port and one read port, with registered read.
module ceht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/cfi_edge_hash_table.sv
// Top level: bucketed hash table of control-flow edges.
// Flow: hash the source (S_HASH, S_BMOD), fetch the fill count (S_FILL, S_FILLW), scan
// bucket slots (S_SLOT, S_SLOTW), compare targets (S_TGT, S_TGTW), append, then S_DONE.
// One transaction at a time; busy stays high until its result strobe.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears all fill counts in a pass over every bucket (S_CLEAR, busy).
module cfi_edge_hash_table
  import ceht_pkg::*;
#(
  parameter int NUM_BUCKETS = NumBucketsDef,
  parameter int SLOTS_PER_BUCKET = SlotsPerBucketDef,
  parameter int TARGETS_PER_SOURCE = TargetsPerSourceDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int CW = $clog2(TARGETS_PER_SOURCE + 1);
  localparam int SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int GW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TGTS = SLOTS * TARGETS_PER_SOURCE;
  localparam int XW = (TGTS > 1) ? $clog2(TGTS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BMOD, S_FILL, S_FILLW, S_SLOT, S_SLOTW,
    S_TGT, S_TGTW, S_APPEND, S_DONE
  } state_t;

  state_t      state_r;
  in_item_t    item_r;
  logic [31:0] crc_r;
  logic [BW-1:0] bucket_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] slot_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] tidx_r;
  logic          seen_r;
  logic [BW:0]   clr_r;
  logic [2:0]    status_r;
  logic [2:0]    index_r;
  logic          out_valid_r;

  // memories
  logic          f_we;   logic [BW-1:0] f_wa;   logic [FW-1:0] f_wd;
  logic [FW-1:0] f_rd;
  logic          s_we;   logic [GW-1:0] s_wa, s_ra;  logic [31:0] s_wd, s_rd;
  logic [CW-1:0] c_wd, c_rd;
  logic          t_we;   logic [XW-1:0] t_wa, t_ra;  logic [31:0] t_wd, t_rd;
  logic          c_we;

  logic [GW-1:0] slot_g;
  assign slot_g = GW'(bucket_r) * GW'(SLOTS_PER_BUCKET) + GW'(slot_r);

  ceht_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(bucket_r), .rdata(f_rd));
  ceht_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_src (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  ceht_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_cnt (
    .clk, .we(c_we), .waddr(s_wa), .wdata(c_wd), .raddr(s_ra), .rdata(c_rd));
  ceht_ram #(.WIDTH(32), .DEPTH(TGTS)) u_tgt (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

  assign s_ra = slot_g;
  assign t_ra = XW'(slot_g) * XW'(TARGETS_PER_SOURCE) + XW'(tidx_r);
  logic is_ins;
  assign is_ins = (item_r.op == OP_INSERT);

  always_comb begin
    f_we = 1'b0; f_wa = bucket_r; f_wd = fill_r + FW'(1);
    s_we = 1'b0; s_wa = slot_g; s_wd = item_r.source_addr;
    c_we = 1'b0; c_wd = CW'(1);
    t_we = 1'b0; t_wa = t_ra; t_wd = item_r.target_addr;
    if (state_r == S_CLEAR) begin
      f_we = 1'b1; f_wa = clr_r[BW-1:0]; f_wd = '0;
    end
    if (state_r == S_APPEND) begin
      t_we = 1'b1;
      c_we = 1'b1;
      if (seen_r) begin
        c_wd = cnt_r + CW'(1);
      end else begin
        s_we = 1'b1; f_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + (BW+1)'(1);
          if (clr_r == (BW+1)'(NUM_BUCKETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          item_r <= in_item;
          state_r <= S_HASH;
        end
        S_HASH: begin
          // bytes of the source, low first
          crc_r <= ~crc32_byte(crc32_byte(crc32_byte(crc32_byte(32'hFFFFFFFF,
                   item_r.source_addr[7:0]), item_r.source_addr[15:8]),
                   item_r.source_addr[23:16]), item_r.source_addr[31:24]);
          state_r <= S_BMOD;
        end
        S_BMOD: begin
          bucket_r <= BW'(crc_r % NUM_BUCKETS);
          slot_r <= '0; seen_r <= 1'b0; tidx_r <= '0;
          state_r <= S_FILL;
        end
        S_FILL: state_r <= S_FILLW;
        S_FILLW: begin
          fill_r <= f_rd;
          state_r <= S_SLOT;
        end
        S_SLOT: begin
          if (slot_r >= fill_r) begin
            if (!is_ins) begin
              status_r <= ST_NOT_FOUND; index_r <= '0; state_r <= S_DONE;
            end else if (fill_r >= FW'(SLOTS_PER_BUCKET)) begin
              status_r <= ST_BUCKET_FULL; index_r <= '0; state_r <= S_DONE;
            end else begin
              tidx_r <= '0;
              status_r <= ST_INSERTED; index_r <= '0; state_r <= S_APPEND;
            end
          end else begin
            state_r <= S_SLOTW;
          end
        end
        S_SLOTW: begin
          tidx_r <= '0;
          cnt_r <= c_rd;
          if (s_rd == item_r.source_addr) begin
            seen_r <= 1'b1; state_r <= S_TGT;
          end else begin
            slot_r <= slot_r + FW'(1); state_r <= S_SLOT;
          end
        end
        S_TGT: begin
          if (tidx_r >= cnt_r) begin
            if (!is_ins) begin
              slot_r <= slot_r + FW'(1); state_r <= S_SLOT;
            end else if (cnt_r >= CW'(TARGETS_PER_SOURCE)) begin
              status_r <= ST_LIST_FULL; index_r <= '0; state_r <= S_DONE;
            end else begin
              status_r <= ST_INSERTED; index_r <= 3'(cnt_r);
              state_r <= S_APPEND;
            end
          end else begin
            state_r <= S_TGTW;
          end
        end
        S_TGTW: begin
          if (t_rd == item_r.target_addr) begin
            status_r <= is_ins ? ST_PRESENT : ST_FOUND;
            index_r <= 3'(tidx_r);
            state_r <= S_DONE;
          end else begin
            tidx_r <= tidx_r + CW'(1); state_r <= S_TGT;
          end
        end
        S_APPEND: state_r <= S_DONE;
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // tidx_r during append equals cnt for append, 0 for a new slot
  always_comb begin
    busy = (state_r != S_IDLE);
    out_valid = out_valid_r;
    out_item.status = status_r;
    out_item.target_index = index_r;
  end
endmodule

>>> design/ceht_checker.sv
// Port-level checker for the edge hash table, bound to the top level.
`include "cfi_edge_hash_table_defines.svh"
module ceht_checker
  import ceht_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);
  `CEHT_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `CEHT_ASSERT_IMP(a_status_legal, clk, rst_n, out_valid, out_item.status <= ST_LIST_FULL)
  `CEHT_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `CEHT_ASSERT_IMP(a_idx_zero, clk, rst_n,
    out_valid && (out_item.status == ST_NOT_FOUND || out_item.status == ST_BUCKET_FULL ||
    out_item.status == ST_LIST_FULL), out_item.target_index == 3'd0)
endmodule

bind cfi_edge_hash_table ceht_checker u_ceht_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item));
